// ===== hdl/sliding_window_sender_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window sender assertion macros
// Implication and next-cycle checks on clk_i with async reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_MACROS_SVH
`define SLIDING_WINDOW_SENDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sws check failed");
`define SWS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sws check failed");
`else
`define SWS_ASSERT_IMP(label, ante, cons)
`define SWS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== hdl/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender package
// Types, codes and constants shared by the sender modules.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 16;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned RES_IDX_W      = 4;
  localparam int unsigned APB_ADDR_W     = 5;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TICK  = 2'd2
  } sws_cmd_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_DOWN  = 2'd2,
    ST_RETRY = 2'd3
  } sws_status_e;

  typedef enum logic [2:0] {
    REG_FILE_BYTES    = 3'd0,
    REG_PAYLOAD_BYTES = 3'd1,
    REG_PACKET_COUNT  = 3'd2,
    REG_WINDOW_SLOTS  = 3'd3,
    REG_RESEND_TICKS  = 3'd4,
    REG_RETRY_LIMIT   = 3'd5,
    REG_SILENCE_TICKS = 3'd6
  } sws_reg_e;

  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_SEND_NEW = 4'd2,
    OP_DONE_CHK = 4'd3,
    OP_SCAN_RD  = 4'd4,
    OP_SCAN_EV  = 4'd5,
    OP_EMIT_MUL = 4'd6,
    OP_EMIT_OUT = 4'd7
  } sws_op_e;

  typedef enum logic [1:0] {
    R_SEND = 2'd0,
    R_CHK  = 2'd1,
    R_SCAN = 2'd2,
    R_EMIT = 2'd3
  } sws_route_e;

  typedef struct packed {
    logic [31:0] file_bytes;
    logic [14:0] payload_bytes;
    logic [31:0] packet_count;
    logic [4:0]  window_slots;
    logic [15:0] resend_ticks;
    logic [3:0]  retry_limit;
    logic [15:0] silence_ticks;
  } sws_cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] ack_number;
  } sws_cmd_t;

  typedef struct packed {
    logic        send_valid;
    logic [31:0] send_seq;
    logic [14:0] payload_length;
    logic        is_resend;
    logic [1:0]  status;
    logic        last;
  } sws_res_t;

  typedef struct packed {
    sws_route_e route;
    logic       can_send;
    logic       scan_more;
    logic       scan_fail;
    logic       more_res;
    logic       out_fire;
  } sws_stat_t;

endpackage

// ===== hdl/sws_if.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface sws_cmd_if import sws_pkg::*;;
  logic     valid;
  logic     ready;
  sws_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sws_res_if import sws_pkg::*;;
  logic     valid;
  logic     ready;
  sws_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int unsigned Width = 36,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sws_regs.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender register file
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module sws_regs import sws_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output sws_cfg_t              cfg_o
);

  sws_cfg_t cfg_q;
  logic     wr_en;
  sws_reg_e idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = sws_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.file_bytes    <= 32'd0;
      cfg_q.payload_bytes <= 15'd1;
      cfg_q.packet_count  <= 32'd1;
      cfg_q.window_slots  <= 5'd1;
      cfg_q.resend_ticks  <= 16'd3;
      cfg_q.retry_limit   <= 4'd5;
      cfg_q.silence_ticks <= 16'd30;
    end else if (wr_en) begin
      unique case (idx)
        REG_FILE_BYTES:    cfg_q.file_bytes    <= pwdata;
        REG_PAYLOAD_BYTES: cfg_q.payload_bytes <= pwdata[14:0];
        REG_PACKET_COUNT:  cfg_q.packet_count  <= pwdata;
        REG_WINDOW_SLOTS:  cfg_q.window_slots  <= pwdata[4:0];
        REG_RESEND_TICKS:  cfg_q.resend_ticks  <= pwdata[15:0];
        REG_RETRY_LIMIT:   cfg_q.retry_limit   <= pwdata[3:0];
        REG_SILENCE_TICKS: cfg_q.silence_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILE_BYTES:    prdata = cfg_q.file_bytes;
      REG_PAYLOAD_BYTES: prdata = {17'd0, cfg_q.payload_bytes};
      REG_PACKET_COUNT:  prdata = cfg_q.packet_count;
      REG_WINDOW_SLOTS:  prdata = {27'd0, cfg_q.window_slots};
      REG_RESEND_TICKS:  prdata = {16'd0, cfg_q.resend_ticks};
      REG_RETRY_LIMIT:   prdata = {28'd0, cfg_q.retry_limit};
      REG_SILENCE_TICKS: prdata = {16'd0, cfg_q.silence_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/sws_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender controller
// Sequences accept, send, scan and result transfer steps.
// ----------------------------------------------------------------------------
module sws_ctrl import sws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  sws_stat_t stat_i,
  output sws_op_e   op_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEND    = 8'b0000_0010,
    S_CHK     = 8'b0000_0100,
    S_SCAN_RD = 8'b0000_1000,
    S_SCAN_EV = 8'b0001_0000,
    S_MUL     = 8'b0010_0000,
    S_OUT     = 8'b0100_0000,
    S_WAIT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = OP_NONE;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_o = OP_ACCEPT;
          unique case (stat_i.route)
            R_SEND:  state_d = S_SEND;
            R_CHK:   state_d = S_CHK;
            R_SCAN:  state_d = S_SCAN_RD;
            default: state_d = S_MUL;
          endcase
        end
      end
      S_SEND: begin
        op_o = OP_SEND_NEW;
        if (!stat_i.can_send) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        op_o    = OP_DONE_CHK;
        state_d = S_MUL;
      end
      S_SCAN_RD: begin
        if (stat_i.scan_more) begin
          op_o    = OP_SCAN_RD;
          state_d = S_SCAN_EV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SCAN_EV: begin
        op_o    = OP_SCAN_EV;
        state_d = stat_i.scan_fail ? S_MUL : S_SCAN_RD;
      end
      S_MUL: begin
        op_o    = OP_EMIT_MUL;
        state_d = S_OUT;
      end
      S_OUT: begin
        op_o    = OP_EMIT_OUT;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.out_fire) begin
          state_d = stat_i.more_res ? S_MUL : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/sws_dp.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender datapath
// Window state, slot memory, result list and output register.
// ----------------------------------------------------------------------------
module sws_dp import sws_pkg::*; #(
  parameter int unsigned WindowMax = WINDOW_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sws_cfg_t  cfg_i,
  input  sws_op_e   op_i,
  input  sws_cmd_t  cmd_i,
  input  logic      res_ready_i,
  output logic      res_valid_o,
  output sws_res_t  res_data_o,
  output sws_stat_t stat_o
);

  localparam int unsigned SlotW = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned EffW  = $clog2(WindowMax + 1);
  localparam int unsigned CmpW  = (EffW > 5) ? EffW : 5;
  localparam logic [SlotW:0]     WinN   = (SlotW + 1)'(WindowMax);
  localparam logic [CNT_W-1:0]   ResMax = CNT_W'(MAX_RESULTS);
  localparam logic [CmpW-1:0]    WinCmp = CmpW'(WindowMax);

  logic [31:0]      base_q, next_q, tick_q, last_ack_q, scan_seq_q;
  logic [SlotW-1:0] base_slot_q, next_slot_q, scan_slot_q;
  sws_status_e      status_q;
  logic             started_q;
  logic [CNT_W-1:0] count_q, ptr_q;
  logic [31:0]      rbuf_seq_q [MAX_RESULTS];
  logic             rbuf_rs_q  [MAX_RESULTS];
  logic             em_vld_q, em_rs_q;
  logic [31:0]      em_seq_q;
  logic [46:0]      em_off_q;
  logic             res_valid_q;
  sws_res_t         res_q;

  logic             active, in_range, silent, can_send, scan_more, due, scan_fail;
  logic [31:0]      tick_inc, ack_diff;
  logic [EffW-1:0]  eff;
  logic [32:0]      limit;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] new_base_slot, next_slot_nx, scan_slot_nx;
  logic [35:0]      rd_data, wr_data;
  logic [31:0]      rd_tick;
  logic [3:0]       rd_retries;
  logic             ram_we;
  logic [SlotW-1:0] ram_waddr;
  sws_route_e       route;
  logic [47:0]      off_sum, file48;
  logic [14:0]      len;
  logic [CNT_W-1:0] ptr_inc;
  logic             out_fire;

  assign active   = started_q && (status_q == ST_RUN);
  assign in_range = (cmd_i.ack_number >= base_q) && (cmd_i.ack_number < next_q);
  assign tick_inc = tick_q + 32'd1;
  assign silent   = (tick_inc - last_ack_q) > {16'd0, cfg_i.silence_ticks};

  always_comb begin
    if (cfg_i.window_slots == 5'd0) begin
      eff = EffW'(1);
    end else if (CmpW'(cfg_i.window_slots) > WinCmp) begin
      eff = EffW'(WindowMax);
    end else begin
      eff = EffW'(cfg_i.window_slots);
    end
  end

  assign limit    = {1'b0, base_q} + 33'(eff);
  assign can_send = (count_q < ResMax) && (next_q < cfg_i.packet_count) &&
                    ({1'b0, next_q} < limit);

  assign ack_diff      = cmd_i.ack_number + 32'd1 - base_q;
  assign slot_sum      = {1'b0, base_slot_q} + ack_diff[SlotW:0];
  assign new_base_slot = (slot_sum >= WinN) ? SlotW'(slot_sum - WinN) : slot_sum[SlotW-1:0];
  assign next_slot_nx  = ({1'b0, next_slot_q} == WinN - 1'b1) ? '0 : next_slot_q + 1'b1;
  assign scan_slot_nx  = ({1'b0, scan_slot_q} == WinN - 1'b1) ? '0 : scan_slot_q + 1'b1;

  assign scan_more  = (scan_seq_q < next_q) && (count_q < ResMax);
  assign rd_tick    = rd_data[35:4];
  assign rd_retries = rd_data[3:0];
  assign due        = (tick_q - rd_tick) >= {16'd0, cfg_i.resend_ticks};
  assign scan_fail  = due && (rd_retries >= cfg_i.retry_limit);

  always_comb begin
    unique case (cmd_i.command)
      CMD_START: route = started_q ? R_EMIT : R_SEND;
      CMD_ACK:   route = !active ? R_EMIT : (in_range ? R_SEND : R_CHK);
      CMD_TICK:  route = (!active || silent) ? R_EMIT : R_SCAN;
      default:   route = R_EMIT;
    endcase
  end

  assign ram_we    = ((op_i == OP_SEND_NEW) && can_send) ||
                     ((op_i == OP_SCAN_EV) && due && !scan_fail);
  assign ram_waddr = (op_i == OP_SEND_NEW) ? next_slot_q : scan_slot_q;
  assign wr_data   = (op_i == OP_SEND_NEW) ? {tick_q, 4'd0} : {tick_q, rd_retries + 4'd1};

  sws_ram #(
    .Width (36),
    .Depth (WindowMax)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .re_i    (op_i == OP_SCAN_RD),
    .raddr_i (scan_slot_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      tick_q      <= '0;
      last_ack_q  <= '0;
      base_slot_q <= '0;
      next_slot_q <= '0;
      status_q    <= ST_RUN;
      started_q   <= 1'b0;
      count_q     <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        res_valid_q <= 1'b0;
        ptr_q       <= ptr_inc;
      end
      unique case (op_i)
        OP_ACCEPT: begin
          count_q <= '0;
          ptr_q   <= '0;
          unique case (cmd_i.command)
            CMD_START: begin
              if (!started_q) begin
                started_q  <= 1'b1;
                last_ack_q <= tick_q;
              end
            end
            CMD_ACK: begin
              if (active) begin
                last_ack_q <= tick_q;
                if (in_range) begin
                  base_q      <= cmd_i.ack_number + 32'd1;
                  base_slot_q <= new_base_slot;
                end
              end
            end
            CMD_TICK: begin
              tick_q <= tick_inc;
              if (active && silent) begin
                status_q <= ST_DOWN;
              end
            end
            default: ;
          endcase
        end
        OP_SEND_NEW: begin
          if (can_send) begin
            count_q     <= count_q + 1'b1;
            next_q      <= next_q + 32'd1;
            next_slot_q <= next_slot_nx;
          end
        end
        OP_DONE_CHK: begin
          if (base_q >= cfg_i.packet_count) begin
            status_q <= ST_DONE;
          end
        end
        OP_SCAN_EV: begin
          if (scan_fail) begin
            status_q <= ST_RETRY;
          end else if (due) begin
            count_q <= count_q + 1'b1;
          end
        end
        OP_EMIT_OUT: res_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign off_sum = {1'b0, em_off_q} + 48'(cfg_i.payload_bytes);
  assign file48  = 48'(cfg_i.file_bytes);
  always_comb begin
    if (off_sum > file48) begin
      len = ({1'b0, em_off_q} >= file48) ? 15'd0 : 15'(cfg_i.file_bytes - em_off_q[31:0]);
    end else begin
      len = cfg_i.payload_bytes;
    end
  end

  assign ptr_inc  = ptr_q + 1'b1;
  assign out_fire = res_valid_q && res_ready_i;

  always_ff @(posedge clk_i) begin
    if (op_i == OP_ACCEPT) begin
      scan_seq_q  <= base_q;
      scan_slot_q <= base_slot_q;
    end
    if ((op_i == OP_SEND_NEW) && can_send) begin
      rbuf_seq_q[count_q[RES_IDX_W-1:0]] <= next_q;
      rbuf_rs_q[count_q[RES_IDX_W-1:0]]  <= 1'b0;
    end
    if (op_i == OP_SCAN_EV) begin
      scan_seq_q  <= scan_seq_q + 32'd1;
      scan_slot_q <= scan_slot_nx;
      if (due && !scan_fail) begin
        rbuf_seq_q[count_q[RES_IDX_W-1:0]] <= scan_seq_q;
        rbuf_rs_q[count_q[RES_IDX_W-1:0]]  <= 1'b1;
      end
    end
    if (op_i == OP_EMIT_MUL) begin
      em_vld_q <= (count_q != '0);
      em_seq_q <= (count_q != '0) ? rbuf_seq_q[ptr_q[RES_IDX_W-1:0]] : 32'd0;
      em_rs_q  <= (count_q != '0) && rbuf_rs_q[ptr_q[RES_IDX_W-1:0]];
      em_off_q <= rbuf_seq_q[ptr_q[RES_IDX_W-1:0]] * cfg_i.payload_bytes;
    end
    if (op_i == OP_EMIT_OUT) begin
      res_q.send_valid     <= em_vld_q;
      res_q.send_seq       <= em_seq_q;
      res_q.payload_length <= em_vld_q ? len : 15'd0;
      res_q.is_resend      <= em_rs_q;
      res_q.status         <= status_q;
      res_q.last           <= (ptr_inc >= count_q);
    end
  end

  assign res_valid_o      = res_valid_q;
  assign res_data_o       = res_q;
  assign stat_o.route     = route;
  assign stat_o.can_send  = can_send;
  assign stat_o.scan_more = scan_more;
  assign stat_o.scan_fail = scan_fail;
  assign stat_o.more_res  = ptr_inc < count_q;
  assign stat_o.out_fire  = out_fire;

endmodule

// ===== hdl/sliding_window_sender.sv =====
// Flow: a start or ack with new sends runs accept, send, done check, then result steps;
// a tick scans each in-flight slot in turn (slot RAM read then update).
// Each result is formed, then output, and waits for the result side; stalls hold it.
// One command item at a time; ready returns the cycle after the last transfer.
// Reset clears window state, timers and status; the slot RAM is not cleared.
// ----------------------------------------------------------------------------
// Sliding window sender
// Go-back-N transmit control: send orders, acks, timeouts and retries.
// ----------------------------------------------------------------------------
`include "sliding_window_sender_macros.svh"
module sliding_window_sender import sws_pkg::*; #(
  parameter int unsigned WindowMax = WINDOW_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sws_cmd_if.sink               cmd_i,
  sws_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  sws_cfg_t  cfg;
  sws_stat_t stat;
  sws_op_e   op;

  sws_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (stat),
    .op_o        (op)
  );

  sws_dp #(
    .WindowMax (WindowMax)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_i        (op),
    .cmd_i       (cmd_i.data),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_data_o  (res_o.data),
    .stat_o      (stat)
  );

  `SWS_ASSERT_NXT(a_no_res_after_cmd, cmd_i.valid && cmd_i.ready, !res_o.valid)
  `SWS_ASSERT_IMP(a_res_blocks_cmd, res_o.valid, !cmd_i.ready)
  `SWS_ASSERT_IMP(a_empty_is_last, res_o.valid && !res_o.data.send_valid,
                  res_o.data.last && (res_o.data.send_seq == 32'd0))

endmodule

// ===== sim/sliding_window_sender_tb.sv =====
// ----------------------------------------------------------------------------
// Sliding window sender testbench
// Drives start, ack and tick commands with random gaps, stalls the result
// channel at random, programs the registers over APB between phases and
// checks every send order against an in-bench model of the sender.
// ----------------------------------------------------------------------------
module sliding_window_sender_tb import sws_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sws_cmd_if cmd_if();
  sws_res_if res_if();

  sliding_window_sender dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd_if), .res_o(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // register mirror
  logic [31:0] file_bytes_q, packet_count_q;
  logic [14:0] payload_bytes_q;
  logic [4:0]  window_slots_q;
  logic [15:0] resend_ticks_q, silence_ticks_q;
  logic [3:0]  retry_limit_q;
  // sender state
  logic [31:0] win_base, win_next, now_tick, ack_tick;
  logic [31:0] sent_tick [16];
  logic [3:0]  retries [16];
  logic [1:0]  run_st;
  logic        running;

  sws_res_t pending_sends[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 0;

  function automatic int unsigned gap_draw();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [31:0] eff_window();
    if (window_slots_q == 0) return 1;
    if (window_slots_q > 16) return 16;
    return window_slots_q;
  endfunction

  function automatic logic [14:0] pkt_len(logic [31:0] seq);
    longint unsigned p, off, f;
    p = payload_bytes_q;
    off = longint'(seq) * p;
    f = file_bytes_q;
    if (off + p > f) return (off >= f) ? 15'd0 : 15'(f - off);
    return 15'(p);
  endfunction

  function automatic void order_new(ref sws_res_t res[$]);
    longint unsigned lim;
    lim = longint'(win_base) + eff_window();
    while (res.size() < MAX_RESULTS && win_next < packet_count_q &&
           longint'(win_next) < lim) begin
      res.push_back('{send_valid: 1'b1, send_seq: win_next,
                      payload_length: pkt_len(win_next), is_resend: 1'b0,
                      status: ST_RUN, last: 1'b0});
      sent_tick[win_next[3:0]] = now_tick;
      retries[win_next[3:0]] = 0;
      win_next = win_next + 1;
    end
  endfunction

  function automatic void predict_sends(sws_cmd_e cmd, logic [31:0] ack);
    sws_res_t res[$];
    logic [31:0] seq;
    if (cmd == CMD_START) begin
      if (!running) begin
        running = 1;
        ack_tick = now_tick;
        order_new(res);
        if (win_base >= packet_count_q) run_st = ST_DONE;
      end
    end else if (cmd == CMD_ACK) begin
      if (running && run_st == ST_RUN) begin
        ack_tick = now_tick;
        if (ack >= win_base && ack < win_next) begin
          win_base = ack + 1;
          order_new(res);
        end
        if (win_base >= packet_count_q) run_st = ST_DONE;
      end
    end else if (cmd == CMD_TICK) begin
      now_tick = now_tick + 1;
      if (running && run_st == ST_RUN) begin
        if (now_tick - ack_tick > 32'(silence_ticks_q)) begin
          run_st = ST_DOWN;
        end else begin
          seq = win_base;
          while (seq < win_next && res.size() < MAX_RESULTS) begin
            if (now_tick - sent_tick[seq[3:0]] >= 32'(resend_ticks_q)) begin
              if (retries[seq[3:0]] >= retry_limit_q) begin
                run_st = ST_RETRY;
                break;
              end
              res.push_back('{send_valid: 1'b1, send_seq: seq,
                              payload_length: pkt_len(seq), is_resend: 1'b1,
                              status: ST_RUN, last: 1'b0});
              sent_tick[seq[3:0]] = now_tick;
              retries[seq[3:0]] = retries[seq[3:0]] + 1;
            end
            seq = seq + 1;
          end
        end
      end
    end
    if (res.size() == 0) res.push_back('0);
    foreach (res[i]) begin
      res[i].status = run_st;
      res[i].last = (i == res.size() - 1);
      pending_sends.push_back(res[i]);
    end
  endfunction

  // result channel: random stalls
  initial begin
    int unsigned n;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = gap_draw();
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(res_if.valid && res_if.ready)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    sws_res_t got, exp;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (pending_sends.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp = pending_sends.pop_front();
        if (got.send_valid !== exp.send_valid || got.send_seq !== exp.send_seq ||
            got.payload_length !== exp.payload_length ||
            got.is_resend !== exp.is_resend || got.status !== exp.status ||
            got.last !== exp.last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_cmd(sws_cmd_e cmd, logic [31:0] ack);
    int unsigned n;
    n = gap_draw();
    if (n > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    cmd_if.data <= '{command: cmd, ack_number: ack};
    cmd_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    predict_sends(cmd, ack);
    @(negedge clk_i);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (pending_sends.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(sws_reg_e r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(r) << 2;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    unique case (r)
      REG_FILE_BYTES:    file_bytes_q = v;
      REG_PAYLOAD_BYTES: payload_bytes_q = v[14:0];
      REG_PACKET_COUNT:  packet_count_q = v;
      REG_WINDOW_SLOTS:  window_slots_q = v[4:0];
      REG_RESEND_TICKS:  resend_ticks_q = v[15:0];
      REG_RETRY_LIMIT:   retry_limit_q = v[3:0];
      REG_SILENCE_TICKS: silence_ticks_q = v[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] ack_in_flight();
    if (win_next > win_base) return win_base + $urandom_range(0, win_next - win_base - 1);
    return win_base;
  endfunction

  task automatic test_before_start();
    write_reg(REG_FILE_BYTES, 32'd2500);
    write_reg(REG_PAYLOAD_BYTES, 32'd1000);
    write_reg(REG_PACKET_COUNT, 32'd5);
    write_reg(REG_WINDOW_SLOTS, 32'd0);
    send_cmd(CMD_ACK, 32'd0);
    send_cmd(CMD_TICK, 32'd0);
    send_cmd(CMD_ACK, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_start_and_resend();
    send_cmd(CMD_START, 32'd0);
    send_cmd(CMD_START, 32'd0);
    send_cmd(CMD_ACK, 32'd0);
    send_cmd(CMD_ACK, 32'd100);
    repeat (3) send_cmd(CMD_TICK, 32'd0);
    drain();
  endtask

  task automatic test_full_window();
    write_reg(REG_WINDOW_SLOTS, 32'd31);
    write_reg(REG_RESEND_TICKS, 32'd1);
    write_reg(REG_RETRY_LIMIT, 32'd15);
    write_reg(REG_SILENCE_TICKS, 32'd65535);
    quiet = 1;
    send_cmd(CMD_ACK, 32'd1);
    send_cmd(CMD_TICK, 32'd0);
    quiet = 0;
    drain();
    write_reg(REG_PACKET_COUNT, 32'hFFFF_FFFF);
    write_reg(REG_FILE_BYTES, 32'hFFFF_FFFF);
    write_reg(REG_PAYLOAD_BYTES, 32'd32748);
    send_cmd(CMD_ACK, win_next - 1);
    send_cmd(CMD_TICK, 32'd0);
    send_cmd(CMD_ACK, ack_in_flight());
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WINDOW_SLOTS, $urandom_range(1, 16));
      write_reg(REG_RESEND_TICKS, $urandom_range(1, 6));
      write_reg(REG_PAYLOAD_BYTES, (ph == 5) ? 32748 : $urandom_range(1, 4000));
      write_reg(REG_FILE_BYTES, (ph == 0) ? 0 : $urandom);
      quiet = (ph == 2);
      for (int i = 0; i < 38; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_cmd(CMD_ACK, ack_in_flight());
        else if (pick < 76) send_cmd(CMD_ACK, $urandom);
        else if (pick < 98) send_cmd(CMD_TICK, $urandom);
        else send_cmd(CMD_START, $urandom);
      end
      quiet = 0;
      drain();
    end
  endtask

  task automatic test_retries_exhausted();
    write_reg(REG_RETRY_LIMIT, 32'd0);
    write_reg(REG_RESEND_TICKS, 32'd1);
    send_cmd(CMD_TICK, 32'd0);
    send_cmd(CMD_ACK, ack_in_flight());
    send_cmd(CMD_TICK, 32'd0);
    drain();
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    file_bytes_q = 0; payload_bytes_q = 1; packet_count_q = 1; window_slots_q = 1;
    resend_ticks_q = 3; retry_limit_q = 5; silence_ticks_q = 30;
    win_base = 0; win_next = 0; now_tick = 0; ack_tick = 0;
    run_st = ST_RUN; running = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_before_start();
    test_start_and_resend();
    test_full_window();
    test_random_traffic();
    test_retries_exhausted();
    if (mismatches == 0 && pending_sends.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
